### rtl/core/lcdnq_pkg.sv
// Shared types and constants for the character display nibble queue sender.
// Used by the RAM wrapper clients, the controller, the datapath and the top level.
`timescale 1ns / 1ps

package lcdnq_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int BYTE_W      = 8;
  localparam int NIB_W       = 4;
  localparam int ENTRY_W     = BYTE_W + 1;  // type bit above the byte

  // Operation codes of an input item
  localparam logic [1:0] OP_WR_CMD  = 2'd0;
  localparam logic [1:0] OP_WR_DATA = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  // Input item
  typedef struct packed {
    logic [1:0]        op;
    logic [BYTE_W-1:0] byte_in;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic             status;
    logic [NIB_W-1:0] pin_data;
    logic             pin_rs;
    logic             pin_rw;
    logic             pin_enable;
    logic             sending;
    logic             last;
  } out_item_t;

  // Transfer phase of the byte being sent
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_POP    = 2'd1,
    ST_SECOND = 2'd2
  } ctrl_state_e;

  // Result source in the datapath
  typedef enum logic {
    RES_AFTER = 1'b0,  // pins after this step
    RES_DROP  = 1'b1   // old pins with enable dropped
  } res_sel_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic     write;
    logic     reject;
    logic     pop;
    logic     step_low;
    logic     step_end;
    logic     load;
    res_sel_e sel;
    logic     last;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic   full;
    logic   empty;
    phase_e phase;
    logic   out_free;
  } dp_sts_t;

endpackage

### rtl/core/lcdnq_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No package dependency.
`timescale 1ns / 1ps

module lcdnq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/lcdnq_ctrl.sv
// Controller state machine: accepts items and sequences datapath commands.
// Depends on lcdnq_pkg.
`timescale 1ns / 1ps

module lcdnq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [1:0]         in_op_i,
  output logic               in_stall_o,
  input  lcdnq_pkg::dp_sts_t sts_i,
  output lcdnq_pkg::dp_cmd_t cmd_o
);
  import lcdnq_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        take;

  // Accept only while idle and the result register can take a result
  assign in_stall_o = !((state_q == ST_IDLE) && sts_i.out_free);
  assign take       = in_valid_i && !in_stall_o;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take && (in_op_i == OP_TICK)) begin
          if (sts_i.phase == PH_HIGH) begin
            state_d = ST_SECOND;
          end else if ((sts_i.phase == PH_IDLE) && !sts_i.empty) begin
            state_d = ST_POP;
          end
        end
      end
      ST_POP: begin
        state_d = ST_IDLE;
      end
      ST_SECOND: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Command outputs
  always_comb begin
    cmd_o = '0;
    cmd_o.sel  = RES_AFTER;
    cmd_o.last = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          unique case (in_op_i)
            OP_WR_CMD, OP_WR_DATA: begin
              cmd_o.write  = !sts_i.full;
              cmd_o.reject = sts_i.full;
              cmd_o.load   = 1'b1;
            end
            OP_TICK: begin
              if (sts_i.phase == PH_HIGH) begin
                cmd_o.step_low = 1'b1;
                cmd_o.load     = 1'b1;
                cmd_o.sel      = RES_DROP;
                cmd_o.last     = 1'b0;
              end else if (sts_i.phase == PH_LOW) begin
                cmd_o.step_end = 1'b1;
                cmd_o.load     = 1'b1;
              end else begin
                // queued byte waits for the registered read data in ST_POP
                cmd_o.load = sts_i.empty;
              end
            end
            default: begin
              cmd_o.load = 1'b1;
            end
          endcase
        end
      end
      ST_POP: begin
        cmd_o.pop  = 1'b1;
        cmd_o.load = 1'b1;
      end
      ST_SECOND: begin
        cmd_o.load = sts_i.out_free;
      end
      default: begin
        cmd_o.load = 1'b0;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/core/lcdnq_dp.sv
// Datapath: byte queue with pointers and count, pin levels, transfer phase
// and the result register. Depends on lcdnq_pkg and lcdnq_ram.
`timescale 1ns / 1ps

module lcdnq_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lcdnq_pkg::in_item_t  in_data_i,
  input  lcdnq_pkg::dp_cmd_t   cmd_i,
  output lcdnq_pkg::dp_sts_t   sts_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lcdnq_pkg::out_item_t out_data_o
);
  import lcdnq_pkg::*;

  logic [PTR_W-1:0]   head_q, head_d;
  logic [PTR_W-1:0]   tail_q, tail_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [NIB_W-1:0]   cur_lo_q, cur_lo_d;
  phase_e             phase_q, phase_d;
  logic [NIB_W-1:0]   pin_data_q, pin_data_d;
  logic               pin_rs_q, pin_rs_d;
  logic               pin_e_q, pin_e_d;
  logic               out_valid_q;
  out_item_t          out_q, res;
  logic [ENTRY_W-1:0] wr_entry;
  logic [ENTRY_W-1:0] rd_entry;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + PTR_W'(1);
    end
    return n;
  endfunction

  // Queue entry: type bit above the byte
  assign wr_entry = {in_data_i.op[0], in_data_i.byte_in};

  lcdnq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.write),
    .waddr_i(tail_q),
    .wdata_i(wr_entry),
    .raddr_i(head_q),
    .rdata_o(rd_entry)
  );

  // Status towards the controller
  assign sts_o.full     = (count_q == CNT_W'(QUEUE_DEPTH));
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.phase    = phase_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  // Advance queue pointers, phase and pin levels
  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    cur_lo_d   = cur_lo_q;
    phase_d    = phase_q;
    pin_data_d = pin_data_q;
    pin_rs_d   = pin_rs_q;
    pin_e_d    = pin_e_q;
    if (cmd_i.write) begin
      tail_d  = next_ptr(tail_q);
      count_d = count_q + CNT_W'(1);
    end
    if (cmd_i.pop) begin
      head_d     = next_ptr(head_q);
      count_d    = count_q - CNT_W'(1);
      cur_lo_d   = rd_entry[NIB_W-1:0];
      pin_data_d = rd_entry[BYTE_W-1:NIB_W];
      pin_rs_d   = rd_entry[BYTE_W];
      pin_e_d    = 1'b1;
      phase_d    = PH_HIGH;
    end
    if (cmd_i.step_low) begin
      pin_data_d = cur_lo_q;
      pin_e_d    = 1'b1;
      phase_d    = PH_LOW;
    end
    if (cmd_i.step_end) begin
      pin_e_d = 1'b0;
      phase_d = PH_IDLE;
    end
  end

  // Build the result from the pins after the step, or the dropped strobe
  always_comb begin
    res.status   = cmd_i.reject;
    res.pin_rw   = 1'b0;
    res.last     = cmd_i.last;
    res.pin_rs   = pin_rs_d;
    if (cmd_i.sel == RES_DROP) begin
      res.pin_data   = pin_data_q;
      res.pin_enable = 1'b0;
      res.sending    = 1'b1;
    end else begin
      res.pin_data   = pin_data_d;
      res.pin_enable = pin_e_d;
      res.sending    = (phase_d != PH_IDLE);
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      cur_lo_q   <= '0;
      phase_q    <= PH_IDLE;
      pin_data_q <= '0;
      pin_rs_q   <= 1'b0;
      pin_e_q    <= 1'b0;
    end else begin
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
      cur_lo_q   <= cur_lo_d;
      phase_q    <= phase_d;
      pin_data_q <= pin_data_d;
      pin_rs_q   <= pin_rs_d;
      pin_e_q    <= pin_e_d;
    end
  end

  // Hold the result until its transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/core/lcd_nibble_queue_sender.sv
// Top level of the character display nibble queue sender.
// Depends on lcdnq_pkg, lcdnq_ctrl and lcdnq_dp.
`timescale 1ns / 1ps

// Queues command and data bytes for a 4-bit character display and sends one
// byte over three timer ticks, high nibble first, reporting the pin levels
// after every item. A write, an ignored code, the final tick of a byte or a
// tick with nothing queued is done without leaving the idle state, and a new
// item can then be accepted while the output does not stall. A tick that
// starts a byte passes through the pop state, as the queue RAM read is
// registered. The middle tick of a byte gives two results and waits in the
// second state while the output stalls, as one result register carries both.
// A write to a full queue is dropped and flagged in the status bit. The queue
// holds QUEUE_DEPTH entries; its RAM needs no clearing after reset.
module lcd_nibble_queue_sender (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  lcdnq_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lcdnq_pkg::out_item_t out_data_o
);
  import lcdnq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequence the items
  lcdnq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_op_i   (in_data_i.op),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Queue, pins and result register
  lcdnq_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
